// File: rtl/assert_macros.svh
// assertion helpers, clocked on clock and quiet while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define VPQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// same-cycle implication check
`define VPQ_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/vpq_pkg.sv
`default_nettype none

package vpq_pkg;

   // field widths
   localparam int KIND_W   = 2;
   localparam int VOICE_W  = 8;
   localparam int LEVEL_W  = 8;
   localparam int TIME_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 4;
   localparam int DELAY_W  = 16;

   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [VOICE_W-1:0]  voice_type;
   typedef logic [TIME_W-1:0]   time_type;

   // request kinds
   localparam kind_type KIND_ENQ  = 2'd0;
   localparam kind_type KIND_TICK = 2'd1;
   localparam kind_type KIND_BATT = 2'd2;

   // response status codes
   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_INVALID = 2'd1;
   localparam status_type ST_FULL    = 2'd2;
   localparam status_type ST_NONE    = 2'd3;

   // register map
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic REG_DELAY      = 1'b0;
   localparam logic REG_ZERO_VOICE = 1'b1;

   // reset values and limits
   localparam logic [DELAY_W-1:0] DELAY_RESET      = 16'd2000;
   localparam voice_type          ZERO_VOICE_RESET = 8'd106;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX        = 8'd100;

   // latched request payload
   typedef struct packed {
      kind_type           kind;
      voice_type          prompt_id;
      logic [LEVEL_W-1:0] charge_pct;
      logic               system_ready;
      time_type           now_ms;
      logic               player_busy;
      logic               play_ok;
   } item_type;

endpackage

`default_nettype wire

// File: rtl/vpq_req_if.sv
`default_nettype none

interface vpq_req_if import vpq_pkg::*; ();
   logic               valid;
   logic               ready;
   kind_type           kind;
   voice_type          prompt_id;
   logic [LEVEL_W-1:0] charge_pct;
   logic               system_ready;
   time_type           now_ms;
   logic               player_busy;
   logic               play_ok;

   modport source (
      output valid, kind, prompt_id, charge_pct, system_ready, now_ms, player_busy,
             play_ok,
      input  ready
   );

   modport sink (
      input  valid, kind, prompt_id, charge_pct, system_ready, now_ms, player_busy,
             play_ok,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/vpq_rsp_if.sv
`default_nettype none

interface vpq_rsp_if import vpq_pkg::*; ();
   logic               valid;
   logic               ready;
   status_type         status;
   logic               play_issue;
   voice_type          play_id;
   time_type           fail_total;
   logic [COUNT_W-1:0] queue_count;

   modport source (
      output valid, status, play_issue, play_id, fail_total, queue_count,
      input  ready
   );

   modport sink (
      input  valid, status, play_issue, play_id, fail_total, queue_count,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/vpq_ram.sv
`default_nettype none

module vpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 15
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: rtl/voice_prompt_queue_scheduler.sv
// voice prompt queue scheduler
// req channel: one request per item (enqueue prompt, task tick or battery
// announce); rsp channel: exactly one response per request, in order.
// the prompt ids sit in a ring of QUEUE_SLOTS entries in a single-port-read
// ram; one slot stays empty so at most QUEUE_SLOTS-1 prompts wait.
// sequence: a request is taken in the idle cycle, which also reads the head
// entry from the ram; the next cycle evaluates the request, writes the ram
// for an enqueue and loads the response register. the response is valid
// once that register is loaded, and no new request is taken until the
// evaluate step is done.
// a new request can be taken while the previous response still waits.
// if rsp is stalled when a result is ready, the block holds in the evaluate
// step and takes no new request until the response register frees up.
// reset (synchronous, active high) empties the queue, clears the delay
// state and the failure counter, and sets the delay register to 2000 ms and
// the battery-zero voice to 106. no clearing pass is needed.
// configuration: apb-style writes, delay at address 0, zero voice at 4;
// the user must write them only while idle; the block does not enforce this.
`default_nettype none
`include "assert_macros.svh"

module voice_prompt_queue_scheduler import vpq_pkg::*; #(
   parameter int QUEUE_SLOTS = 15
) (
   input  logic              clock,
   input  logic              reset,
   vpq_req_if.sink           req,
   vpq_rsp_if.source         rsp,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   localparam int IDX_W = $clog2(QUEUE_SLOTS);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   item_type item_ff;
   logic [IDX_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic delay_started_ff, delay_started_in;
   time_type ready_time_ff, ready_time_in;
   time_type fail_ff, fail_in;
   logic [DELAY_W-1:0] delay_ff;
   voice_type zero_voice_ff;

   status_type status_ff, status_in;
   logic issue_ff, issue_in;
   voice_type pid_ff, pid_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic accept, out_free, load;
   logic mem_we;
   voice_type head_data;
   logic [IDX_W-1:0] tail_next, head_next;
   time_type elapsed;
   logic [IDX_W:0] waiting;
   logic [IDX_W+COUNT_W-1:0] waiting_ext;

   // handshakes
   assign accept   = req.valid && req.ready;
   assign req.ready = (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign load     = (state_ff == ST_EXEC) && out_free;

   // queue ram, head read at acceptance
   vpq_ram #(
      .WIDTH(VOICE_W),
      .DEPTH(QUEUE_SLOTS)
   ) u_queue_ram (
      .clock(clock),
      .we   (mem_we),
      .waddr(tail_ff),
      .wdata(item_ff.prompt_id),
      .re   (accept),
      .raddr(head_ff),
      .rdata(head_data)
   );

   // ring pointer stepping
   assign tail_next = (tail_ff == IDX_W'(QUEUE_SLOTS - 1)) ? '0 : tail_ff + 1'b1;
   assign head_next = (head_ff == IDX_W'(QUEUE_SLOTS - 1)) ? '0 : head_ff + 1'b1;
   assign elapsed   = item_ff.now_ms - ready_time_ff;

   // evaluate the latched request
   always_comb begin
      head_in          = head_ff;
      tail_in          = tail_ff;
      delay_started_in = delay_started_ff;
      ready_time_in    = ready_time_ff;
      fail_in          = fail_ff;
      status_in        = ST_NONE;
      issue_in         = 1'b0;
      pid_in           = '0;
      mem_we           = 1'b0;
      unique case (item_ff.kind)
         KIND_ENQ: begin
            if (item_ff.prompt_id == '0) begin
               status_in = ST_INVALID;
            end else if (tail_next == head_ff) begin
               status_in = ST_FULL;
            end else begin
               mem_we    = load;
               tail_in   = tail_next;
               status_in = ST_OK;
            end
         end
         KIND_BATT: begin
            if (item_ff.charge_pct > LEVEL_MAX) begin
               status_in = ST_INVALID;
            end else begin
               issue_in  = 1'b1;
               pid_in    = (item_ff.charge_pct == '0) ? zero_voice_ff
                                                      : item_ff.charge_pct;
               status_in = item_ff.play_ok ? ST_OK : ST_NONE;
            end
         end
         KIND_TICK: begin
            if (!item_ff.system_ready) begin
               delay_started_in = 1'b0;
            end else if (!delay_started_ff) begin
               ready_time_in    = item_ff.now_ms;
               delay_started_in = 1'b1;
            end else if (elapsed >= {{(TIME_W-DELAY_W){1'b0}}, delay_ff}) begin
               if (!item_ff.player_busy && head_ff != tail_ff) begin
                  issue_in = 1'b1;
                  pid_in   = head_data;
                  if (item_ff.play_ok) begin
                     head_in   = head_next;
                     status_in = ST_OK;
                  end else begin
                     fail_in = fail_ff + 32'd1;
                  end
               end
            end
         end
         default: begin
            status_in = ST_NONE;
         end
      endcase
   end

   // entries waiting after the update
   always_comb begin
      if (tail_in >= head_in) begin
         waiting = {1'b0, tail_in} - {1'b0, head_in};
      end else begin
         waiting = {1'b0, tail_in} + (IDX_W+1)'(QUEUE_SLOTS) - {1'b0, head_in};
      end
      waiting_ext = {{COUNT_W{1'b0}}, waiting[IDX_W-1:0]};
      count_in    = waiting_ext[COUNT_W-1:0];
   end

   // sequencer and response valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         head_ff          <= '0;
         tail_ff          <= '0;
         delay_started_ff <= 1'b0;
         ready_time_ff    <= '0;
         fail_ff          <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            head_ff          <= head_in;
            tail_ff          <= tail_in;
            delay_started_ff <= delay_started_in;
            ready_time_ff    <= ready_time_in;
            fail_ff          <= fail_in;
         end
      end
   end

   // request latch and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.kind         <= req.kind;
         item_ff.prompt_id    <= req.prompt_id;
         item_ff.charge_pct   <= req.charge_pct;
         item_ff.system_ready <= req.system_ready;
         item_ff.now_ms       <= req.now_ms;
         item_ff.player_busy  <= req.player_busy;
         item_ff.play_ok      <= req.play_ok;
      end
      if (load) begin
         status_ff <= status_in;
         issue_ff  <= issue_in;
         pid_ff    <= pid_in;
         count_ff  <= count_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.play_issue  = issue_ff;
   assign rsp.play_id     = pid_ff;
   assign rsp.fail_total  = fail_ff;
   assign rsp.queue_count = count_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff      <= DELAY_RESET;
         zero_voice_ff <= ZERO_VOICE_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[2])
            REG_DELAY:      delay_ff      <= pwdata[DELAY_W-1:0];
            REG_ZERO_VOICE: zero_voice_ff <= pwdata[VOICE_W-1:0];
            default:        delay_ff      <= delay_ff;
         endcase
      end
   end

   assign pready = 1'b1;

   // register read back
   always_comb begin
      unique case (paddr[2])
         REG_DELAY:      prdata = {{(CSR_DW-DELAY_W){1'b0}}, delay_ff};
         REG_ZERO_VOICE: prdata = {{(CSR_DW-VOICE_W){1'b0}}, zero_voice_ff};
         default:        prdata = '0;
      endcase
   end

   // checks
   `VPQ_ASSERT_IMP(a_head_moves_on_tick, !$past(reset) && !$stable(head_ff), $past(state_ff) == ST_EXEC && $past(item_ff.kind) == KIND_TICK, "head moved outside a tick")
   `VPQ_ASSERT_IMP(a_fail_steps_by_one, !$past(reset) && !$stable(fail_ff), fail_ff == $past(fail_ff) + 32'd1, "failure count jumped")
   `VPQ_ASSERT(a_no_write_over_head, !mem_we || tail_next != head_ff, "enqueue wrote into a full ring")

endmodule

`default_nettype wire
